>>> sv/sipq_pkg.sv
// Shared types and constants of the sorted-insert priority queue.
`timescale 1ns / 1ps
package sipq_pkg;

    localparam int CAPACITY = 16;
    localparam int VALUE_W  = 32;
    localparam int PRIO_W   = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int STAT_W   = 2;

    // Packed output tdata layout, lowest bit first.
    localparam int OUT_HV_LO   = 0;
    localparam int OUT_HP_LO   = OUT_HV_LO + VALUE_W;
    localparam int OUT_RV_LO   = OUT_HP_LO + PRIO_W;
    localparam int OUT_RP_LO   = OUT_RV_LO + VALUE_W;
    localparam int OUT_OCC_LO  = OUT_RP_LO + PRIO_W;
    localparam int OUT_EMPTY   = OUT_OCC_LO + CNT_W;
    localparam int OUT_FULL    = OUT_EMPTY + 1;
    localparam int OUT_USED    = OUT_FULL + 1;
    localparam int OUT_DATA_W  = ((OUT_USED + 7) / 8) * 8;
    localparam int IN_USED     = VALUE_W + PRIO_W;
    localparam int IN_DATA_W   = ((IN_USED + 7) / 8) * 8;

    typedef struct packed {
        logic [PRIO_W-1:0]  prio;
        logic [VALUE_W-1:0] value;
    } t_entry;

    typedef enum logic {
        KIND_PUSH = 1'b0,
        KIND_POP  = 1'b1
    } t_kind;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_POP_EMPTY = 2'd1,
        STAT_PUSH_FULL = 2'd2
    } t_status;

    // Per-cycle command broadcast to every cell.
    typedef struct packed {
        logic   push;
        logic   pop;
        t_entry new_entry;
    } t_cell_ctl;

endpackage

>>> sv/sorted_insert_priority_queue.sv
// Top level of the sorted-insert priority queue: cell row, count and result register.
//
//  channel | dir | tdata (low bit up)                         | tuser
//  --------+-----+--------------------------------------------+------------------
//  s       | in  | entry_value[31:0], entry_priority[47:32]   | kind (0 push, 1 pop)
//  m       | out | head_value, head_priority, removed_value,  | status
//          |     | removed_priority, occupancy, is_empty,     |
//          |     | is_full, zero pad to 104 bits              |
//
// One transaction per clock while the master side is not stalled: every cell
// compares its stored priority with the incoming one in the same cycle, so the
// single compare-and-shift of the row sets the rate, and the registered result appears in the cycle after acceptance.
// Reset clears the entry count and the result valid flag; slot contents are
// not cleared, as only slots below the count are ever read.
// A result held by a stalled master side blocks the slave side only while it
// cannot be replaced in the same cycle it is taken.
`timescale 1ns / 1ps
module sorted_insert_priority_queue (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [sipq_pkg::IN_DATA_W-1:0]    i_s_tdata,  // entry_value, entry_priority
    input  logic                              i_s_tuser,  // kind
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [sipq_pkg::OUT_DATA_W-1:0]   o_m_tdata,  // head_value, head_priority,
                                                          // removed_value, removed_priority,
                                                          // occupancy, is_empty, is_full
    output logic [sipq_pkg::STAT_W-1:0]       o_m_tuser   // status
);
    import sipq_pkg::*;

    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [OUT_DATA_W-1:0] n_out_data;
    t_status               r_out_stat;
    t_status               n_out_stat;

    logic      w_accept;
    logic      w_empty;
    logic      w_full;
    t_kind     w_kind;
    t_cell_ctl w_ctl;
    t_entry    w_removed;
    t_entry    w_head;

    logic   [CAPACITY-1:0] w_occ;
    logic   [CAPACITY-1:0] w_take;
    t_entry                w_entry [CAPACITY];
    t_entry                w_next  [CAPACITY];

    // Accept while the result register is free or being drained.
    assign o_s_tready = !r_out_valid || i_m_tready;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_kind     = t_kind'(i_s_tuser);
    assign w_empty    = (r_count == '0);
    assign w_full     = (r_count == CNT_W'(CAPACITY));

    // Drop a push when full, ignore a pop when empty.
    always_comb begin
        w_ctl.push            = w_accept && (w_kind == KIND_PUSH) && !w_full;
        w_ctl.pop             = w_accept && (w_kind == KIND_POP) && !w_empty;
        w_ctl.new_entry.value = i_s_tdata[VALUE_W-1:0];
        w_ctl.new_entry.prio  = i_s_tdata[VALUE_W +: PRIO_W];
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            assign w_occ[g] = (r_count > CNT_W'(g));
            if (g == 0) begin : g_first
                sipq_cell u_cell (
                    .i_clk       (i_clk),
                    .i_ctl       (w_ctl),
                    .i_occ       (w_occ[g]),
                    .i_take_left (1'b0),
                    .i_left      (w_ctl.new_entry),
                    .i_right     (w_entry[g+1]),
                    .o_take      (w_take[g]),
                    .o_entry     (w_entry[g]),
                    .o_next      (w_next[g])
                );
            end else if (g == CAPACITY - 1) begin : g_last
                // Last slot frees itself on a pop; what it takes in is never read.
                sipq_cell u_cell (
                    .i_clk       (i_clk),
                    .i_ctl       (w_ctl),
                    .i_occ       (w_occ[g]),
                    .i_take_left (w_take[g-1]),
                    .i_left      (w_entry[g-1]),
                    .i_right     (w_entry[g]),
                    .o_take      (w_take[g]),
                    .o_entry     (w_entry[g]),
                    .o_next      (w_next[g])
                );
            end else begin : g_mid
                sipq_cell u_cell (
                    .i_clk       (i_clk),
                    .i_ctl       (w_ctl),
                    .i_occ       (w_occ[g]),
                    .i_take_left (w_take[g-1]),
                    .i_left      (w_entry[g-1]),
                    .i_right     (w_entry[g+1]),
                    .o_take      (w_take[g]),
                    .o_entry     (w_entry[g]),
                    .o_next      (w_next[g])
                );
            end
        end
    endgenerate

    // Next count and the result of this transaction.
    always_comb begin
        n_count    = r_count;
        n_out_stat = STAT_OK;
        w_removed  = '0;
        priority if (w_ctl.push) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_ctl.pop) begin
            n_count   = r_count - CNT_W'(1);
            w_removed = w_entry[0];
        end else if (w_accept && (w_kind == KIND_POP)) begin
            n_out_stat = STAT_POP_EMPTY;
        end else if (w_accept) begin
            n_out_stat = STAT_PUSH_FULL;
        end else begin
            n_count = r_count;
        end

        w_head = (n_count == '0) ? '0 : w_next[0];

        n_out_data                           = '0;
        n_out_data[OUT_HV_LO +: VALUE_W]     = w_head.value;
        n_out_data[OUT_HP_LO +: PRIO_W]      = w_head.prio;
        n_out_data[OUT_RV_LO +: VALUE_W]     = w_removed.value;
        n_out_data[OUT_RP_LO +: PRIO_W]      = w_removed.prio;
        n_out_data[OUT_OCC_LO +: CNT_W]      = n_count;
        n_out_data[OUT_EMPTY]                = (n_count == '0);
        n_out_data[OUT_FULL]                 = (n_count == CNT_W'(CAPACITY));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload: load on acceptance, hold otherwise.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= n_out_data;
            r_out_stat <= n_out_stat;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_stat;

endmodule

>>> sv/sipq_cell.sv
// One slot of the sorted row: compare with the incoming entry, hold, insert or shift.
`timescale 1ns / 1ps
module sipq_cell (
    input  logic               i_clk,
    input  sipq_pkg::t_cell_ctl i_ctl,
    input  logic               i_occ,        // slot holds a live entry
    input  logic               i_take_left,  // insertion point lies before this slot
    input  sipq_pkg::t_entry   i_left,
    input  sipq_pkg::t_entry   i_right,
    output logic               o_take,       // insertion point at or before this slot
    output sipq_pkg::t_entry   o_entry,
    output sipq_pkg::t_entry   o_next
);
    import sipq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;
    logic   w_gt;

    // Strictly higher priority goes in front; equal keeps arrival order.
    assign w_gt   = i_occ && ($signed(i_ctl.new_entry.prio) > $signed(r_entry.prio));
    assign o_take = w_gt || !i_occ;

    always_comb begin
        n_entry = r_entry;
        priority if (i_ctl.push) begin
            priority if (i_take_left) begin
                n_entry = i_left;
            end else if (o_take) begin
                n_entry = i_ctl.new_entry;
            end else begin
                n_entry = r_entry;
            end
        end else if (i_ctl.pop) begin
            n_entry = i_right;
        end else begin
            n_entry = r_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_next  = n_entry;

endmodule

>>> sv/sipq_chk.sv
// Port-level checks of the sorted-insert priority queue, bound to the top level.
`timescale 1ns / 1ps
module sipq_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_s_tready,
    input logic                            i_s_tvalid,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [sipq_pkg::OUT_DATA_W-1:0] o_m_tdata,
    input logic [sipq_pkg::STAT_W-1:0]     o_m_tuser
);
    import sipq_pkg::*;

    logic [CNT_W-1:0] w_occ;
    assign w_occ = o_m_tdata[OUT_OCC_LO +: CNT_W];

    // Empty flag agrees with occupancy, and an empty queue shows a zero head.
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[OUT_EMPTY] == (w_occ == '0)) &&
                       (!o_m_tdata[OUT_EMPTY] || (o_m_tdata[OUT_RV_LO-1:0] == '0)))
        else $error("empty flag or head inconsistent with occupancy");

    // Full flag agrees with occupancy, and a dropped push only happens when full.
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[OUT_FULL] == (w_occ == CNT_W'(CAPACITY))) &&
                       ((o_m_tuser != STAT_PUSH_FULL) || o_m_tdata[OUT_FULL]))
        else $error("full flag inconsistent");

    // A pop on an empty queue leaves it empty and removes nothing.
    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser == STAT_POP_EMPTY)) |->
            o_m_tdata[OUT_EMPTY] && (o_m_tdata[OUT_RV_LO +: VALUE_W + PRIO_W] == '0))
        else $error("pop on empty queue altered state or reported removal");

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled result changed");

    // Every accepted transaction yields a result on the next cycle.
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> o_m_tvalid)
        else $error("accepted transaction produced no result");

endmodule

bind sorted_insert_priority_queue sipq_chk u_sipq_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .i_s_tvalid (i_s_tvalid),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
